// ----- rtl/core/rpf_pkg.sv -----
package rpf_pkg;

	// framing characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ESC   = 8'h7D;
	localparam logic [7:0] ESC_XOR  = 8'h20;
	localparam logic [3:0] NIB_MASK = 4'hF;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// step positions in the back end's per-command step vector
	localparam int STEP_START = 0;
	localparam int STEP_ESC   = 1;
	localparam int STEP_DATA  = 2;
	localparam int STEP_HASH  = 3;
	localparam int STEP_HI    = 4;
	localparam int STEP_LO    = 5;
	localparam int STEP_CNT   = 6;

	typedef logic [STEP_CNT-1:0] step_vec_t;

	// input word
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       final_byte;
		logic       empty_packet;
	} item_t;

	// output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
	} word_t;

	// classified command handed from front to back
	typedef struct packed {
		logic       start;
		logic       esc;
		logic       data_en;
		logic       close;
		logic [7:0] data;
	} cmd_t;

	// uppercase ascii hex digit of the low nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [3:0] n;
		n = v & NIB_MASK;
		if (n < 4'd10) begin
			hex_digit = 8'h30 + {4'h0, n};
		end else begin
			hex_digit = 8'h37 + {4'h0, n};
		end
	endfunction

	// bytes that must be escaped inside a packet
	function automatic logic is_special(input logic [7:0] b);
		is_special = (b == CH_START) || (b == CH_END) || (b == CH_STAR) || (b == CH_ESC);
	endfunction

endpackage

// ----- rtl/core/rpf_front.sv -----
module rpf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rpf_pkg::item_t item,
	output logic           push_valid,
	output rpf_pkg::cmd_t  push_cmd,
	input  logic           queue_full
);

	logic in_packet_q;
	logic accept;
	logic special;

	assign accept     = item_valid && !queue_full;
	assign item_stall = queue_full;
	assign push_valid = item_valid;

	// classify the incoming word into a framing command
	always_comb begin
		special          = rpf_pkg::is_special(item.payload_byte);
		push_cmd.start   = !in_packet_q;
		push_cmd.data_en = !item.empty_packet;
		push_cmd.esc     = !item.empty_packet && special;
		push_cmd.close   = item.empty_packet || item.final_byte;
		push_cmd.data    = special ? (item.payload_byte ^ rpf_pkg::ESC_XOR)
		                           : item.payload_byte;
	end

	// packet open flag, follows the input stream alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
		end else if (accept) begin
			in_packet_q <= !(item.empty_packet || item.final_byte);
		end
	end

endmodule

// ----- rtl/core/rpf_queue.sv -----
module rpf_queue #(
	parameter int DEPTH = rpf_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  rpf_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          head_valid,
	output rpf_pkg::cmd_t head_cmd,
	input  logic          pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	rpf_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/rpf_back.sv -----
module rpf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  rpf_pkg::cmd_t  head_cmd,
	output logic           pop,
	output logic           word_valid,
	input  logic           word_stall,
	output rpf_pkg::word_t word
);

	rpf_pkg::step_vec_t done_q;
	rpf_pkg::step_vec_t steps;
	rpf_pkg::step_vec_t pending;
	rpf_pkg::step_vec_t pick;
	logic [7:0]         sum_q;
	logic               valid_q;
	rpf_pkg::word_t     word_q;
	logic               advance;
	logic               emit;
	logic               last_step;
	rpf_pkg::word_t     next_word;

	assign advance    = !valid_q || !word_stall;
	assign emit       = advance && head_valid;
	assign word_valid = valid_q;
	assign word       = word_q;

	// steps still owed for the head command, lowest first
	always_comb begin
		steps                      = '0;
		steps[rpf_pkg::STEP_START] = head_cmd.start;
		steps[rpf_pkg::STEP_ESC]   = head_cmd.esc;
		steps[rpf_pkg::STEP_DATA]  = head_cmd.data_en;
		steps[rpf_pkg::STEP_HASH]  = head_cmd.close;
		steps[rpf_pkg::STEP_HI]    = head_cmd.close;
		steps[rpf_pkg::STEP_LO]    = head_cmd.close;
		pending   = steps & ~done_q;
		pick      = pending & (~pending + 1'b1);
		last_step = (pending == pick);
		pop       = emit && last_step;
	end

	// byte for the chosen step
	always_comb begin
		next_word.packet_end = 1'b0;
		next_word.out_byte   = head_cmd.data;
		if (pick[rpf_pkg::STEP_START]) begin
			next_word.out_byte = rpf_pkg::CH_START;
		end else if (pick[rpf_pkg::STEP_ESC]) begin
			next_word.out_byte = rpf_pkg::CH_ESC;
		end else if (pick[rpf_pkg::STEP_HASH]) begin
			next_word.out_byte = rpf_pkg::CH_END;
		end else if (pick[rpf_pkg::STEP_HI]) begin
			next_word.out_byte = rpf_pkg::hex_digit(sum_q[7:4]);
		end else if (pick[rpf_pkg::STEP_LO]) begin
			next_word.out_byte   = rpf_pkg::hex_digit(sum_q[3:0]);
			next_word.packet_end = 1'b1;
		end
	end

	// step tracking, checksum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= head_valid;
			end
			if (emit) begin
				done_q <= last_step ? '0 : (done_q | pick);
				if (pick[rpf_pkg::STEP_START] || pick[rpf_pkg::STEP_LO]) begin
					sum_q <= '0;
				end else if (pick[rpf_pkg::STEP_ESC] || pick[rpf_pkg::STEP_DATA]) begin
					sum_q <= sum_q + next_word.out_byte;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (emit) begin
			word_q <= next_word;
		end
	end

endmodule

// ----- rtl/core/rsp_packet_framer.sv -----
// path: each item waits in the command queue; its words are registered at the output
// throughput: one output word per cycle while word_stall is low; an item yields 1 to 6
// words ('$', escape, data, '#', two checksum digits) from the single byte-wide output
// register; input words are taken every cycle while the queue has room
// reset: arst_n clears the open-packet flag, checksum, queue and output valid
module rsp_packet_framer #(
	parameter int QUEUE_DEPTH = rpf_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rpf_pkg::item_t item,
	output logic           word_valid,
	input  logic           word_stall,
	output rpf_pkg::word_t word
);

	logic          push_valid;
	rpf_pkg::cmd_t push_cmd;
	logic          queue_full;
	logic          head_valid;
	rpf_pkg::cmd_t head_cmd;
	logic          pop;

	// classify input words
	rpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// command queue
	rpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// emit framed bytes
	rpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word)
	);

endmodule

// ----- rtl/core/rpf_checker.sv -----
module rpf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           word_valid,
	input logic           word_stall,
	input rpf_pkg::word_t word
);

	logic out_acc;
	logic after_end_q;
	logic after_esc_q;

	assign out_acc = word_valid && !word_stall;

	// track packet boundary and escape prefix on the output stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_end_q <= 1'b1;
			after_esc_q <= 1'b0;
		end else if (out_acc) begin
			after_end_q <= word.packet_end;
			after_esc_q <= (word.out_byte == rpf_pkg::CH_ESC) && !after_esc_q;
		end
	end

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid && $stable(word))
		else $error("stalled word changed");

	// every packet opens with '$' and '$' appears nowhere else
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> ((word.out_byte == rpf_pkg::CH_START) == after_end_q))
		else $error("packet start mismatch");

	// closing word is an uppercase hex digit
	a_end_hex: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && word.packet_end |->
		((word.out_byte >= 8'h30 && word.out_byte <= 8'h39) ||
		 (word.out_byte >= 8'h41 && word.out_byte <= 8'h46)))
		else $error("closing word not a hex digit");

	// escaped byte is one of the four special bytes xor 0x20
	a_escaped: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && after_esc_q |->
		(word.out_byte == 8'h04 || word.out_byte == 8'h03 ||
		 word.out_byte == 8'h0A || word.out_byte == 8'h5D))
		else $error("bad escaped byte");

endmodule

bind rsp_packet_framer rpf_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.word_valid (word_valid),
	.word_stall (word_stall),
	.word       (word)
);
